// ----- design/lsra_pkg.sv -----
// Shared constants, register codes and result type for the linear-scan allocator.
package lsra_pkg;

  localparam int MAX_REGS_DEF = 16;

  localparam int VAR_W      = 16;
  localparam int POINT_W    = 16;
  localparam int SLOT_W     = 16;
  localparam int REG_IDX_W  = 4;
  localparam int NUM_REGS_W = 5;

  // APB-style configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [NUM_REGS_W-1:0] NUM_REGS_RST = NUM_REGS_W'(16);
  localparam logic [SLOT_W-1:0]     SLOT_MAX     = '1;

  // Word index of each configuration register (paddr[CFG_AW-1:2])
  typedef enum logic [CFG_AW-3:0] {
    REG_NUM_REGS = 1'b0
  } cfg_reg_t;

  // One allocation decision
  typedef struct packed {
    logic [VAR_W-1:0]     out_var;
    logic                 spilled;
    logic [REG_IDX_W-1:0] reg_index;
    logic [SLOT_W-1:0]    stack_slot;
    logic                 last;
  } result_t;

endpackage

// ----- design/lsra_in_if.sv -----
// Input channel: one live interval per item.
interface lsra_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsra_pkg::VAR_W-1:0]   var_id;
  logic [lsra_pkg::POINT_W-1:0] start_point;
  logic [lsra_pkg::POINT_W-1:0] end_point;

  modport source (output valid, var_id, start_point, end_point, input ready);
  modport sink (input valid, var_id, start_point, end_point, output ready);
endinterface

// ----- design/lsra_out_if.sv -----
// Result channel: one allocation decision per item.
interface lsra_out_if;
  logic                           valid;
  logic                           ready;
  logic [lsra_pkg::VAR_W-1:0]     out_var;
  logic                           spilled;
  logic [lsra_pkg::REG_IDX_W-1:0] reg_index;
  logic [lsra_pkg::SLOT_W-1:0]    stack_slot;
  logic                           last;

  modport source (output valid, out_var, spilled, reg_index, stack_slot, last, input ready);
  modport sink (input valid, out_var, spilled, reg_index, stack_slot, last, output ready);
endinterface

// ----- design/lsra_cfg.sv -----
// Configuration register file behind the APB-style port.
module lsra_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lsra_pkg::CFG_AW-1:0]          paddr,
  input  logic [lsra_pkg::CFG_DW-1:0]          pwdata,
  output logic [lsra_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready,
  output logic [lsra_pkg::NUM_REGS_W-1:0]      num_regs
);

  logic [lsra_pkg::NUM_REGS_W-1:0] num_regs_r;
  logic [lsra_pkg::NUM_REGS_W-1:0] num_regs_nxt;
  logic [lsra_pkg::CFG_AW-3:0]     word;
  logic                            wr_en;

  assign pready   = 1'b1;
  assign word     = paddr[lsra_pkg::CFG_AW-1:2];
  assign wr_en    = psel & penable & pwrite;
  assign num_regs = num_regs_r;

  // write decode
  always_comb begin
    num_regs_nxt = num_regs_r;
    if (wr_en && (word == lsra_pkg::REG_NUM_REGS)) begin
      num_regs_nxt = pwdata[lsra_pkg::NUM_REGS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_regs_r <= lsra_pkg::NUM_REGS_RST;
    end else begin
      num_regs_r <= num_regs_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (word)
      lsra_pkg::REG_NUM_REGS: prdata = lsra_pkg::CFG_DW'(num_regs_r);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- design/lsra_ctrl.sv -----
// Allocation sequencer: active-interval table, free-register mask and slot counter.
module lsra_ctrl #(
  parameter int MAX_REGS = lsra_pkg::MAX_REGS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lsra_pkg::NUM_REGS_W-1:0] num_regs,
  lsra_in_if.sink                         in_ch,
  lsra_out_if.source                      out_ch
);

  localparam int PW  = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CW  = $clog2(MAX_REGS + 1);
  localparam int VW  = lsra_pkg::VAR_W;
  localparam int EPW = lsra_pkg::POINT_W;
  localparam int EW  = VW + EPW + PW;
  localparam int RIW = lsra_pkg::REG_IDX_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXPIRE = 7'b0000010,
    S_FIND   = 7'b0000100,
    S_CAND   = 7'b0001000,
    S_INSERT = 7'b0010000,
    S_EMIT1  = 7'b0100000,
    S_EMIT2  = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           h_r, h_nxt;
  logic [PW-1:0]           t_r, t_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [CW-1:0]           m_r, m_nxt;
  logic [VW-1:0]           var_r, var_nxt;
  logic [EPW-1:0]          start_r, start_nxt;
  logic [EPW-1:0]          end_r, end_nxt;
  logic [PW-1:0]           new_reg_r, new_reg_nxt;
  logic [MAX_REGS-1:0]     reg_free_r, reg_free_nxt;
  logic [lsra_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [lsra_pkg::SLOT_W-1:0] slot_inc;
  lsra_pkg::result_t       res1_r, res1_nxt;
  lsra_pkg::result_t       res2_r, res2_nxt;
  logic                    two_r, two_nxt;
  lsra_pkg::result_t       out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // active table: {var, end, reg}, one write and one registered read per cycle
  logic [EW-1:0]           mem_r [MAX_REGS];
  logic [EW-1:0]           rdata_r;
  logic                    we;
  logic [PW-1:0]           waddr;
  logic [EW-1:0]           wdata;
  logic [PW-1:0]           raddr;

  logic [VW-1:0]           rd_var;
  logic [EPW-1:0]          rd_end;
  logic [PW-1:0]           rd_reg;
  logic [EPW-1:0]          cmp_b;
  logic                    gt;
  logic                    found;
  logic [PW-1:0]           free_idx;
  logic                    load;
  lsra_pkg::result_t       load_val;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(MAX_REGS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(MAX_REGS - 1) : p - 1'b1;
  endfunction

  assign rd_var = rdata_r[EW-1 -: VW];
  assign rd_end = rdata_r[PW +: EPW];
  assign rd_reg = rdata_r[PW-1:0];

  // shared end-point comparator: expiry against start, otherwise against new end
  assign cmp_b = (state_r == S_EXPIRE) ? start_r : end_r;
  assign gt    = rd_end > cmp_b;

  assign slot_inc = (slot_r == lsra_pkg::SLOT_MAX) ? slot_r : slot_r + 1'b1;

  // lowest free register below num_regs
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = MAX_REGS - 1; i >= 0; i--) begin
      if (reg_free_r[i] && (i < int'(num_regs))) begin
        found    = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    h_nxt        = h_r;
    t_nxt        = t_r;
    pos_nxt      = pos_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    var_nxt      = var_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    new_reg_nxt  = new_reg_r;
    reg_free_nxt = reg_free_r;
    slot_nxt     = slot_r;
    res1_nxt     = res1_r;
    res2_nxt     = res2_r;
    two_nxt      = two_r;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = {var_r, end_r, new_reg_r};
    raddr        = h_r;
    load         = 1'b0;
    load_val     = res1_r;

    unique case (state_r)
      S_IDLE: begin
        raddr = h_r;
        if (in_ch.valid) begin
          var_nxt   = in_ch.var_id;
          start_nxt = in_ch.start_point;
          end_nxt   = in_ch.end_point;
          state_nxt = S_EXPIRE;
        end
      end

      // drop the oldest-ending entries one per cycle
      S_EXPIRE: begin
        if ((n_r != '0) && !gt) begin
          reg_free_nxt[rd_reg] = 1'b1;
          h_nxt                = ptr_inc(h_r);
          n_nxt                = n_r - 1'b1;
          raddr                = ptr_inc(h_r);
        end else begin
          state_nxt = S_FIND;
        end
      end

      // take a free register, else look at the latest-ending entry, else spill the new one
      S_FIND: begin
        raddr = ptr_dec(t_r);
        if (found && (n_r < CW'(MAX_REGS))) begin
          reg_free_nxt[free_idx] = 1'b0;
          new_reg_nxt = free_idx;
          res1_nxt    = '{out_var: var_r, spilled: 1'b0, reg_index: RIW'(free_idx),
                          stack_slot: '0, last: 1'b1};
          two_nxt     = 1'b0;
          pos_nxt     = t_r;
          m_nxt       = n_r;
          n_nxt       = n_r + 1'b1;
          t_nxt       = ptr_inc(t_r);
          state_nxt   = S_INSERT;
        end else if (n_r != '0) begin
          state_nxt = S_CAND;
        end else begin
          res1_nxt  = '{out_var: var_r, spilled: 1'b1, reg_index: '0,
                        stack_slot: slot_r, last: 1'b1};
          two_nxt   = 1'b0;
          slot_nxt  = slot_inc;
          state_nxt = S_EMIT1;
        end
      end

      // steal from the latest-ending entry, or spill the new one
      S_CAND: begin
        if (gt) begin
          new_reg_nxt = rd_reg;
          res1_nxt    = '{out_var: var_r, spilled: 1'b0, reg_index: RIW'(rd_reg),
                          stack_slot: '0, last: 1'b0};
          res2_nxt    = '{out_var: rd_var, spilled: 1'b1, reg_index: '0,
                          stack_slot: slot_r, last: 1'b1};
          two_nxt     = 1'b1;
          slot_nxt    = slot_inc;
          pos_nxt     = ptr_dec(t_r);
          m_nxt       = n_r - 1'b1;
          raddr       = ptr_dec(ptr_dec(t_r));
          state_nxt   = S_INSERT;
        end else begin
          res1_nxt  = '{out_var: var_r, spilled: 1'b1, reg_index: '0,
                        stack_slot: slot_r, last: 1'b1};
          two_nxt   = 1'b0;
          slot_nxt  = slot_inc;
          state_nxt = S_EMIT1;
        end
      end

      // sorted insert: move later-ending entries up one slot per cycle
      S_INSERT: begin
        we    = 1'b1;
        waddr = pos_r;
        if ((m_r != '0) && gt) begin
          wdata   = rdata_r;
          pos_nxt = ptr_dec(pos_r);
          m_nxt   = m_r - 1'b1;
          raddr   = ptr_dec(ptr_dec(pos_r));
        end else begin
          wdata     = {var_r, end_r, new_reg_r};
          state_nxt = S_EMIT1;
        end
      end

      S_EMIT1: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          load_val  = res1_r;
          state_nxt = two_r ? S_EMIT2 : S_IDLE;
        end
      end

      S_EMIT2: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          load_val  = res2_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_nxt       = load_val;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_var    = out_r.out_var;
  assign out_ch.spilled    = out_r.spilled;
  assign out_ch.reg_index  = out_r.reg_index;
  assign out_ch.stack_slot = out_r.stack_slot;
  assign out_ch.last       = out_r.last;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= '0;
      t_r         <= '0;
      n_r         <= '0;
      reg_free_r  <= '1;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      t_r         <= t_nxt;
      n_r         <= n_nxt;
      reg_free_r  <= reg_free_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    m_r       <= m_nxt;
    var_r     <= var_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    new_reg_r <= new_reg_nxt;
    res1_r    <= res1_nxt;
    res2_r    <= res2_nxt;
    two_r     <= two_nxt;
    out_r     <= out_nxt;
  end

  // active table
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_REGS))
    else $error("active count exceeds table depth");

  a_free_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(~reg_free_r) == int'(n_r)))
    else $error("busy registers disagree with active count");

  a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.spilled ? (out_r.reg_index == '0) : (out_r.stack_slot == '0)))
    else $error("unused result field not zero");
`endif

endmodule

// ----- design/linear_scan_register_allocator_unit.sv -----
// Top level of the linear-scan register allocator.
//
// Usage: present live intervals on in_ch (var_id, start_point, end_point) in
// order of nondecreasing start. Each item yields one result on out_ch, or two
// when a register is stolen: first the new variable with the stolen register
// (last = 0), then the displaced variable with its stack slot (last = 1).
// The user writes num_regs via the APB-style port only while the block is idle;
// the block itself does not enforce this.
//
// Flow: one item at a time; in_ch.ready is high only while the sequencer is
// idle. After an item is taken the sequencer expires entries (one per cycle),
// looks for a free register, examines the latest-ending entry when none is
// found, performs the sorted insert when the item enters the table, and emits
// each result; it then returns to idle, where the next item can be taken. The
// active table has one read and one write port, the end-point comparator is
// shared, and a finished result waits in the output register while the next
// item is taken; a stalled receiver holds the sequencer in its emit step.
// Reset: table empty, all registers free, stack slot counter zero, num_regs 16.
module linear_scan_register_allocator_unit #(
  parameter int MAX_REGS = lsra_pkg::MAX_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lsra_in_if.sink                     in_ch,
  lsra_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsra_pkg::CFG_AW-1:0] paddr,
  input  logic [lsra_pkg::CFG_DW-1:0] pwdata,
  output logic [lsra_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  logic [lsra_pkg::NUM_REGS_W-1:0] num_regs;

  lsra_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .num_regs (num_regs)
  );

  lsra_ctrl #(
    .MAX_REGS (MAX_REGS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_regs (num_regs),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

// ----- test/tb_linear_scan_register_allocator_unit.sv -----
// Testbench for the linear-scan register allocator: random and directed intervals.
`timescale 1ns / 100ps

module tb_linear_scan_register_allocator_unit;

  localparam int REG_CAP = lsra_pkg::MAX_REGS_DEF;
  localparam int SETTLE_CYCLES = 2 * REG_CAP + 30;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [lsra_pkg::VAR_W-1:0]   var_id;
    logic [lsra_pkg::POINT_W-1:0] start_point;
    logic [lsra_pkg::POINT_W-1:0] end_point;
  } interval_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lsra_pkg::CFG_AW-1:0] paddr;
  logic [lsra_pkg::CFG_DW-1:0] pwdata;
  logic [lsra_pkg::CFG_DW-1:0] prdata;
  logic pready;

  lsra_in_if  in_ch();
  lsra_out_if out_ch();

  linear_scan_register_allocator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Intervals waiting to be offered, decisions waiting to come back
  interval_t          pending_intervals[$];
  interval_t          on_offer;
  lsra_pkg::result_t  expected_decisions[$];

  // Allocator shadow state
  logic                             live_valid[REG_CAP];
  logic [lsra_pkg::VAR_W-1:0]       live_var[REG_CAP];
  logic [lsra_pkg::POINT_W-1:0]     live_end[REG_CAP];
  logic [lsra_pkg::REG_IDX_W-1:0]   live_reg[REG_CAP];
  logic                             reg_free[REG_CAP];
  logic [lsra_pkg::SLOT_W-1:0]      next_slot;
  logic [lsra_pkg::NUM_REGS_W-1:0]  num_regs_cfg;

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_request;
  logic hold_done;
  int stall_left;
  int mismatch_count;
  int intervals_taken;
  int decisions_checked;
  int grant_count;
  int steal_count;
  int spill_count;
  int settings_used;

  // Sorted insert into the active table; equal ends go after older ones
  function automatic void place_entry(int unsigned n, logic [lsra_pkg::VAR_W-1:0] vid,
                                      logic [lsra_pkg::POINT_W-1:0] end_pt,
                                      logic [lsra_pkg::REG_IDX_W-1:0] rix);
    int unsigned p;
    p = 0;
    if (n >= REG_CAP) return;
    while (p < n && live_end[p] <= end_pt) p++;
    for (int unsigned i = n; i > p; i--) begin
      live_var[i] = live_var[i-1];
      live_end[i] = live_end[i-1];
      live_reg[i] = live_reg[i-1];
    end
    live_var[p] = vid;
    live_end[p] = end_pt;
    live_reg[p] = rix;
    live_valid[n] = 1'b1;
  endfunction

  // Stack slot counter sticks at its top value
  function automatic logic [lsra_pkg::SLOT_W-1:0] take_stack_slot();
    logic [lsra_pkg::SLOT_W-1:0] s;
    s = next_slot;
    if (next_slot != lsra_pkg::SLOT_MAX) next_slot++;
    return s;
  endfunction

  // Expire, then grant / steal / spill; queues the decisions one interval causes
  function automatic void predict_decisions(interval_t it);
    int unsigned n;
    int unsigned usable;
    int unsigned expired;
    int unsigned r;
    logic [lsra_pkg::VAR_W-1:0] old_var;
    logic [lsra_pkg::REG_IDX_W-1:0] old_reg;
    n = 0;
    while (n < REG_CAP && live_valid[n]) n++;
    usable = (num_regs_cfg > REG_CAP) ? REG_CAP : num_regs_cfg;
    expired = 0;
    while (expired < n && live_end[expired] <= it.start_point) begin
      reg_free[live_reg[expired]] = 1'b1;
      expired++;
    end
    if (expired > 0) begin
      for (int unsigned i = 0; i + expired < n; i++) begin
        live_var[i] = live_var[i+expired];
        live_end[i] = live_end[i+expired];
        live_reg[i] = live_reg[i+expired];
      end
      for (int unsigned i = n - expired; i < n; i++) live_valid[i] = 1'b0;
      n -= expired;
    end
    r = 0;
    while (r < usable && !reg_free[r]) r++;
    if (r < usable && n < REG_CAP) begin
      reg_free[r] = 1'b0;
      place_entry(n, it.var_id, it.end_point, lsra_pkg::REG_IDX_W'(r));
      expected_decisions.push_back('{out_var: it.var_id, spilled: 1'b0,
                                     reg_index: lsra_pkg::REG_IDX_W'(r), stack_slot: '0,
                                     last: 1'b1});
      grant_count++;
    end else if (n > 0 && live_end[n-1] > it.end_point) begin
      // latest-ending entry gives up its register
      old_var = live_var[n-1];
      old_reg = live_reg[n-1];
      live_valid[n-1] = 1'b0;
      place_entry(n - 1, it.var_id, it.end_point, old_reg);
      expected_decisions.push_back('{out_var: it.var_id, spilled: 1'b0,
                                     reg_index: old_reg, stack_slot: '0, last: 1'b0});
      expected_decisions.push_back('{out_var: old_var, spilled: 1'b1, reg_index: '0,
                                     stack_slot: take_stack_slot(), last: 1'b1});
      steal_count++;
    end else begin
      expected_decisions.push_back('{out_var: it.var_id, spilled: 1'b1, reg_index: '0,
                                     stack_slot: take_stack_slot(), last: 1'b1});
      spill_count++;
    end
  endfunction

  function automatic void push_interval(int vid, int start_pt, int end_pt);
    interval_t it;
    it.var_id = lsra_pkg::VAR_W'(vid);
    it.start_point = lsra_pkg::POINT_W'(start_pt);
    it.end_point = lsra_pkg::POINT_W'(end_pt);
    pending_intervals.push_back(it);
  endfunction

  // Mostly ordered runs of intervals; a few noise items and ordering breaks
  task automatic queue_intervals(int count);
    int start_i;
    int end_i;
    int span;
    interval_t it;
    start_i = $urandom_range(0, 50000);
    for (int k = 0; k < count; k++) begin
      it.var_id = lsra_pkg::VAR_W'($urandom);
      if ($urandom_range(99) < 8) begin
        it.start_point = lsra_pkg::POINT_W'($urandom);
        it.end_point = lsra_pkg::POINT_W'($urandom);
      end else begin
        if ($urandom_range(99) < 3) start_i = $urandom_range(0, 65535);
        start_i = start_i + $urandom_range(0, 3);
        if (start_i > 65535) start_i = 65535;
        span = ($urandom_range(99) < 15) ? 400 : 40;
        if ($urandom_range(99) < 3) end_i = start_i - $urandom_range(1, 20);
        else end_i = start_i + $urandom_range(0, span);
        if (end_i > 65535) end_i = 65535;
        if (end_i < 0) end_i = 0;
        it.start_point = lsra_pkg::POINT_W'(start_i);
        it.end_point = lsra_pkg::POINT_W'(end_i);
      end
      pending_intervals.push_back(it);
    end
  endtask

  // Wait until every queued item is taken and all decisions are back;
  // checked at the falling edge, once the driver's updates have settled
  task automatic wait_for_idle();
    while (pending_intervals.size() > 0 || in_ch.valid || expected_decisions.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of num_regs, then read it back
  task automatic write_num_regs(logic [lsra_pkg::NUM_REGS_W-1:0] value);
    logic [lsra_pkg::CFG_AW-1:0] addr;
    addr = {lsra_pkg::REG_NUM_REGS, 2'b00};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= lsra_pkg::CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    num_regs_cfg = value;
    settings_used++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== lsra_pkg::CFG_DW'(value)) begin
      $error("num_regs readback: expected %0d, got %0d", value, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("linear_scan_register_allocator_unit: mismatch");
    $finish;
  end

  // Interval driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_decisions(on_offer);
        intervals_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_intervals.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_offer = pending_intervals.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.var_id <= on_offer.var_id;
          in_ch.start_point <= on_offer.start_point;
          in_ch.end_point <= on_offer.end_point;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      stall_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Decision monitor and receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decisions.size() == 0) begin
          $error("unexpected decision for variable %h", out_ch.out_var);
          mismatch_count++;
        end else begin
          lsra_pkg::result_t want;
          want = expected_decisions.pop_front();
          decisions_checked++;
          if (out_ch.out_var !== want.out_var) begin
            $error("out_var: expected %h, got %h", want.out_var, out_ch.out_var);
            mismatch_count++;
          end
          if (out_ch.spilled !== want.spilled) begin
            $error("spilled: expected %b, got %b", want.spilled, out_ch.spilled);
            mismatch_count++;
          end
          if (out_ch.reg_index !== want.reg_index) begin
            $error("reg_index: expected %0d, got %0d", want.reg_index, out_ch.reg_index);
            mismatch_count++;
          end
          if (out_ch.stack_slot !== want.stack_slot) begin
            $error("stack_slot: expected %0d, got %0d", want.stack_slot, out_ch.stack_slot);
            mismatch_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_ch.last);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int phase_regs[8];
    phase_regs = '{16, 1, 5, 2, 12, 16, 3, 8};
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_idle_pct = 9;
    rx_idle_pct = 9;
    hold_request = 1'b0;
    mismatch_count = 0;
    intervals_taken = 0;
    decisions_checked = 0;
    grant_count = 0;
    steal_count = 0;
    spill_count = 0;
    settings_used = 0;
    num_regs_cfg = lsra_pkg::NUM_REGS_RST;
    next_slot = '0;
    for (int i = 0; i < REG_CAP; i++) begin
      live_valid[i] = 1'b0;
      reg_free[i] = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two registers, grant / steal / spill / ties / expiry
    write_num_regs(lsra_pkg::NUM_REGS_W'(2));
    push_interval(1, 0, 10);
    push_interval(2, 1, 20);
    push_interval(3, 2, 15);          // steals from the longer interval
    push_interval(4, 3, 30);          // new one is longest, so it spills
    push_interval(5, 4, 15);          // equal latest end: new one spills
    push_interval(6, 10, 15);         // expiry frees a register
    push_interval(7, 11, 12);         // tie on latest end: newest gives up its register
    push_interval(8, 15, 16);         // several expire at once
    push_interval(9, 15, 14);         // ends before it starts
    push_interval(10, 5, 100);        // start out of order
    push_interval(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_interval(16'h0000, 16'hFFFF, 16'h0000);
    push_interval(16'hAAAA, 16'hFFFF, 16'h5555);
    push_interval(16'h5555, 0, 16'hAAAA);
    wait_for_idle();

    // Directed: full width, then shrink while entries stay active
    write_num_regs(lsra_pkg::NUM_REGS_W'(16));
    push_interval(20, 200, 300);
    push_interval(21, 200, 250);
    push_interval(22, 201, 260);
    push_interval(23, 201, 280);
    wait_for_idle();
    write_num_regs(lsra_pkg::NUM_REGS_W'(1));
    push_interval(24, 202, 240);
    push_interval(25, 202, 400);
    push_interval(26, 203, 203);
    wait_for_idle();

    // Random phases over several register counts
    for (int p = 0; p < 8; p++) begin
      write_num_regs(lsra_pkg::NUM_REGS_W'(phase_regs[p]));
      tx_idle_pct = (p == 2) ? 0 : 9;
      rx_idle_pct = (p == 2) ? 0 : 9;
      queue_intervals(90);
      if (p == 4) hold_request = 1'b1;
      // sender holds back until all decisions are in
      while (pending_intervals.size() > 0 || in_ch.valid || expected_decisions.size() > 0)
        @(negedge clk);
      queue_intervals(85);
      wait_for_idle();
    end

    $display("Ran %0d intervals over %0d num_regs settings: %0d grants, %0d steals, %0d spills;",
             intervals_taken, settings_used, grant_count, steal_count, spill_count);
    $display("%0d decisions checked field by field.", decisions_checked);
    if (mismatch_count == 0) begin
      $display("linear_scan_register_allocator_unit: match");
    end else begin
      $display("linear_scan_register_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- linear_scan_register_allocator_unit.f -----
design/lsra_pkg.sv
design/lsra_in_if.sv
design/lsra_out_if.sv
design/lsra_cfg.sv
design/lsra_ctrl.sv
design/linear_scan_register_allocator_unit.sv
test/tb_linear_scan_register_allocator_unit.sv
